// File: rtl/sairm_pkg.sv
// ----------------------------------------------------------------------------
// sairm_pkg
// Shared types, command codes and helpers for the shift array block.
// ----------------------------------------------------------------------------
`default_nettype none

package sairm_pkg;

    localparam int ENTRY_W = 32;
    localparam int POS_W   = 9;     // holds any cell position up to 256
    localparam int SLOTS   = 32;    // compare tree width, covers any length in use

    typedef logic signed [ENTRY_W-1:0] entry_t;

    localparam entry_t ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_MAX    = 3'd4;

    typedef struct packed {
        logic load;
        logic from_left;
        logic from_right;
        logic clear;
    } cell_ctrl_t;

    function automatic entry_t smax(input entry_t a, input entry_t b);
        return (b > a) ? b : a;
    endfunction

endpackage

`default_nettype wire

// File: rtl/shift_array_insert_remove_max.sv
// ----------------------------------------------------------------------------
// shift_array_insert_remove_max
// Array of signed entries with insert, remove, read, write and find-max.
// ----------------------------------------------------------------------------
// One item at a time. Insert, remove, read and write go to execute, where
// cells shift or load in parallel and the result is registered once the
// output register is free. Find-max adds states MAX1 and MAX2 for the two
// register levels of the compare tree. The result sits in an output
// register, so a new item is accepted while the previous result waits. The
// used length is clamped to 1..min(DEPTH,31); an index at or beyond it flags
// index_error and leaves the array untouched. All entries reset to zero.
`default_nettype none

module shift_array_insert_remove_max #(
    parameter int DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [3:0] index, [35:4] value_in, [39:36] zero
    input  wire logic [2:0]  s_tuser,   // [2:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] value_out
    output logic [0:0]       m_tuser,   // [0] index_error
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);
    import sairm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_MAX1 = 2'd2;
    localparam logic [1:0] ST_MAX2 = 2'd3;

    localparam logic [4:0] LEN_CAP = (DEPTH > 31) ? 5'd31 : 5'(DEPTH);
    localparam int         RD_N    = (DEPTH < 16) ? DEPTH : 16;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [4:0]  len_reg;
    logic [4:0]  len_eff;
    logic [2:0]  cmd_reg;
    logic [3:0]  idx_reg;
    entry_t      val_reg;
    logic        out_valid_reg;
    entry_t      out_data_reg;
    logic        out_err_reg;

    logic        in_accept;
    logic        out_free;
    logic        idx_err;
    logic        load_out;
    logic        upd;
    logic        ins;
    logic        rem;
    logic        wr;
    entry_t      rd_val;
    entry_t      result;
    entry_t      max_val;
    logic [POS_W-1:0] idx9;
    logic [POS_W-1:0] len9;

    entry_t      cell_val [DEPTH];
    cell_ctrl_t  cell_ctrl [DEPTH];
    entry_t      slot [SLOTS];
    logic [DEPTH-1:0] cell_busy;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign len_eff = (len_reg == 5'd0) ? 5'd1 :
                     ((len_reg > LEN_CAP) ? LEN_CAP : len_reg);
    assign idx9    = {5'b0, idx_reg};
    assign len9    = {4'b0, len_eff};
    assign idx_err = (cmd_reg <= CMD_WRITE) && ({1'b0, idx_reg} >= len_eff);

    assign upd = (state_reg == ST_EXEC) && (cmd_reg != CMD_MAX) && out_free && !idx_err;
    assign ins = upd && (cmd_reg == CMD_INSERT);
    assign rem = upd && (cmd_reg == CMD_REMOVE);
    assign wr  = upd && (cmd_reg == CMD_WRITE);

    assign load_out = out_free &&
                      (((state_reg == ST_EXEC) && (cmd_reg != CMD_MAX)) ||
                       (state_reg == ST_MAX2));

    // cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [POS_W-1:0] POS  = POS_W'(i);
        localparam logic [POS_W-1:0] POS1 = POS_W'(i + 1);
        entry_t left_val;
        entry_t right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_left
            assign left_val = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_right
            assign right_val = cell_val[i+1];
        end

        assign cell_ctrl[i].load       = (ins || wr) && (POS == idx9);
        assign cell_ctrl[i].from_left  = ins && (POS > idx9) && (POS < len9);
        assign cell_ctrl[i].from_right = rem && (POS >= idx9) && (POS1 < len9);
        assign cell_ctrl[i].clear      = rem && (POS1 == len9);
        assign cell_busy[i]            = |cell_ctrl[i];

        sairm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[i]),
            .left_val  (left_val),
            .right_val (right_val),
            .load_val  (val_reg),
            .val       (cell_val[i])
        );
    end

    // slots beyond the length in use drop out of the maximum
    for (genvar j = 0; j < SLOTS; j++)
    begin : g_slot
        if (j < DEPTH)
        begin : g_used
            assign slot[j] = (5'(j) < len_eff) ? cell_val[j] : ENTRY_MIN;
        end
        else
        begin : g_pad
            assign slot[j] = ENTRY_MIN;
        end
    end

    sairm_max_tree u_max_tree (
        .clk     (clk),
        .slot    (slot),
        .max_val (max_val)
    );

    always_comb
    begin
        rd_val = '0;
        for (int k = 0; k < RD_N; k++)
        begin
            if (idx_reg == 4'(k))
            begin
                rd_val = cell_val[k];
            end
        end
    end

    always_comb
    begin
        result = '0;
        if (!idx_err)
        begin
            case (cmd_reg)
                CMD_READ:  result = rd_val;
                CMD_WRITE: result = val_reg;
                CMD_MAX:   result = max_val;
                default:   result = '0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg == CMD_MAX)
                begin
                    state_next = ST_MAX1;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAX1:
            begin
                state_next = ST_MAX2;
            end
            ST_MAX2:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= 5'd16;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                len_reg <= cfg_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= s_tuser;
            idx_reg <= s_tdata[3:0];
            val_reg <= s_tdata[35:4];
        end
        if (load_out)
        begin
            out_data_reg <= result;
            out_err_reg  <= idx_err;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_err_reg;

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_EXEC)
        else $error("accepted item did not enter execute");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tdata != 32'd0))
        else $error("index error with nonzero value");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_eff != 5'd0 && len_eff <= LEN_CAP)
        else $error("effective length out of range");

    a_update_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (|cell_busy) |-> load_out)
        else $error("cell update without result");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> state_reg == ST_IDLE)
        else $error("result loaded but block not idle");
`endif

endmodule

`default_nettype wire

// File: rtl/sairm_cell.sv
// ----------------------------------------------------------------------------
// sairm_cell
// One array entry: holds, loads, takes a neighbor's value or clears.
// ----------------------------------------------------------------------------
`default_nettype none

module sairm_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sairm_pkg::cell_ctrl_t ctrl,
    input  wire sairm_pkg::entry_t   left_val,
    input  wire sairm_pkg::entry_t   right_val,
    input  wire sairm_pkg::entry_t   load_val,
    output sairm_pkg::entry_t        val
);
    import sairm_pkg::*;

    entry_t val_reg;
    entry_t val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.load)
        begin
            val_next = load_val;
        end
        else if (ctrl.from_left)
        begin
            val_next = left_val;
        end
        else if (ctrl.from_right)
        begin
            val_next = right_val;
        end
        else if (ctrl.clear)
        begin
            val_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

`default_nettype wire

// File: rtl/sairm_max_tree.sv
// ----------------------------------------------------------------------------
// sairm_max_tree
// Registered signed maximum tree: 32 slots, 8 groups, 2 halves, 1 result.
// ----------------------------------------------------------------------------
`default_nettype none

module sairm_max_tree (
    input  wire logic              clk,
    input  wire sairm_pkg::entry_t slot [sairm_pkg::SLOTS],
    output sairm_pkg::entry_t      max_val
);
    import sairm_pkg::*;

    localparam int GROUPS = SLOTS / 4;
    localparam int HALVES = 2;
    localparam int PER_H  = GROUPS / HALVES;

    entry_t grp_reg  [GROUPS];
    entry_t grp_next [GROUPS];
    entry_t half_reg  [HALVES];
    entry_t half_next [HALVES];

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = smax(smax(slot[4*g], slot[4*g+1]),
                               smax(slot[4*g+2], slot[4*g+3]));
        end
        for (int h = 0; h < HALVES; h++)
        begin
            half_next[h] = smax(smax(grp_reg[PER_H*h], grp_reg[PER_H*h+1]),
                                smax(grp_reg[PER_H*h+2], grp_reg[PER_H*h+3]));
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg  <= grp_next;
        half_reg <= half_next;
    end

    assign max_val = smax(half_reg[0], half_reg[1]);

endmodule

`default_nettype wire
